@@ sv/mzdp_pkg.sv @@
package mzdp_pkg;

    // item kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_TIMEOUT_RELOAD = 3'd0;
    localparam logic [2:0] CFG_EVAL_PERIOD    = 3'd1;
    localparam logic [2:0] CFG_RUN_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_RUN_WRAP       = 3'd3;
    localparam logic [2:0] CFG_COOLDOWN_TICKS = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration values after reset
    localparam logic [7:0]  RST_TIMEOUT_RELOAD = 8'd70;
    localparam logic [7:0]  RST_EVAL_PERIOD    = 8'd15;
    localparam logic [13:0] RST_RUN_LIMIT      = 14'd10000;
    localparam logic [13:0] RST_RUN_WRAP       = 14'd12000;
    localparam logic [15:0] RST_COOLDOWN_TICKS = 16'd600;

    typedef struct packed {
        logic       func;
        logic [2:0] sensor_index;
        logic       report_on;
    } t_request;

    typedef struct packed {
        logic [7:0] sensor_flags;
        logic       motor_on;
        logic       run_indicator;
        logic       single_enable;
        logic       cooldown_active;
    } t_result;

    // control from the main sequencer to the sensor bank
    typedef struct packed {
        logic       clear;
        logic       tick;
        logic       eval;
        logic       report;
        logic [2:0] sensor_index;
        logic       report_on;
    } t_bank_ctrl;

    // live-sensor status after the current tick's aging
    typedef struct packed {
        logic live_any;
        logic live_one;
    } t_bank_stat;

endpackage

@@ sv/mzdp_sensor_bank.sv @@
module mzdp_sensor_bank #(
    parameter int NUM_SENSORS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mzdp_pkg::t_bank_ctrl      i_ctrl,
    input  logic [7:0]                i_reload,
    output mzdp_pkg::t_bank_stat      o_stat,
    output logic [NUM_SENSORS-1:0]    o_flags_next
);

    localparam int LIVE_W = $clog2(NUM_SENSORS + 1);

    logic [7:0]             r_timeout [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] r_flag;
    logic [7:0]             n_timeout [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] n_flag;
    logic [7:0]             aged      [NUM_SENSORS];
    logic [LIVE_W-1:0]      live_cnt;

    // aged timeouts and live count as seen by an evaluation on this tick
    always_comb begin
        live_cnt = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            aged[i] = (r_timeout[i] != 8'd0) ? r_timeout[i] - 8'd1 : 8'd0;
            if (aged[i] != 8'd0) begin
                live_cnt = live_cnt + LIVE_W'(1);
            end
        end
    end

    assign o_stat.live_any = (live_cnt != '0);
    assign o_stat.live_one = (live_cnt == LIVE_W'(1));

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            n_timeout[i] = r_timeout[i];
            n_flag[i]    = r_flag[i];
            if (i_ctrl.clear) begin
                n_timeout[i] = 8'd0;
                n_flag[i]    = 1'b0;
            end else if (i_ctrl.tick) begin
                n_timeout[i] = aged[i];
                if (i_ctrl.eval && aged[i] == 8'd0) begin
                    n_flag[i] = 1'b0;
                end
            end else if (i_ctrl.report && int'(i_ctrl.sensor_index) == i) begin
                n_flag[i] = i_ctrl.report_on;
                if (i_ctrl.report_on) begin
                    n_timeout[i] = i_reload;
                end
            end
        end
    end

    assign o_flags_next = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_timeout[i] <= 8'd0;
            end
        end else begin
            r_flag <= n_flag;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_timeout[i] <= n_timeout[i];
            end
        end
    end

endmodule

@@ sv/multi_zone_demand_pump_controller.sv @@
// demand pump controller for up to NUM_SENSORS zone sensors
// request channel (i_in_valid / o_in_ready / i_in_data) carries either a
// time tick or a sensor report (sensor index plus on/off flag)
// result channel (o_out_valid / i_out_ready / o_out_data) returns one result
// per request: sensor flags, motor drive, run indicator, single-zone enable
// and cooldown status, all as they stand after that request
// the result is registered and shows in the cycle after the request is
// taken; throughput is one request per cycle while the receiver keeps up,
// set by the single next-state pass and the one-deep result register
// when the receiver stalls, the held result stays put and o_in_ready drops
// until it is taken; a new request is taken in the same cycle a result leaves
// the configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) writes one
// register per enabled cycle, to be used only while the block is idle
// reset (i_rst_n low, synchronous) clears all sensor and motor state, loads
// the default configuration and empties the result register
// cooldown ends with the same clearing of state, config values are kept
module multi_zone_demand_pump_controller #(
    parameter int NUM_SENSORS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mzdp_pkg::t_request                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mzdp_pkg::t_result                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [mzdp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mzdp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic [7:0]  r_timeout_reload;
    logic [7:0]  r_eval_period;
    logic [13:0] r_run_limit;
    logic [13:0] r_run_wrap;
    logic [15:0] r_cooldown_ticks;

    // controller state
    logic [7:0]  r_period, n_period;
    logic [13:0] r_run, n_run;
    logic        r_motor, n_motor;
    logic        r_status, n_status;
    logic        r_enable, n_enable;
    logic        r_cool, n_cool;
    logic [15:0] r_elapsed, n_elapsed;

    // result register
    logic                r_out_valid;
    mzdp_pkg::t_result   r_out;
    mzdp_pkg::t_result   n_out;

    logic                      accept;
    logic [7:0]                period_inc;
    logic [13:0]               run_inc;
    logic [15:0]               elapsed_inc;
    mzdp_pkg::t_bank_ctrl      bank_ctrl;
    mzdp_pkg::t_bank_stat      bank_stat;
    logic [NUM_SENSORS-1:0]    flags_next;

    // skid-free handoff: take a request whenever the result slot frees up
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign period_inc  = r_period + 8'd1;
    assign run_inc     = r_run + 14'd1;
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;

    always_comb begin
        n_period  = r_period;
        n_run     = r_run;
        n_motor   = r_motor;
        n_status  = r_status;
        n_enable  = r_enable;
        n_cool    = r_cool;
        n_elapsed = r_elapsed;

        bank_ctrl              = '0;
        bank_ctrl.sensor_index = i_in_data.sensor_index;
        bank_ctrl.report_on    = i_in_data.report_on;

        if (accept) begin
            if (r_cool) begin
                // cooldown: reports are dropped, ticks count toward restart
                if (i_in_data.func == mzdp_pkg::FUNC_TICK) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= r_cooldown_ticks) begin
                        bank_ctrl.clear = 1'b1;
                        n_period  = 8'd0;
                        n_run     = 14'd0;
                        n_motor   = 1'b0;
                        n_status  = 1'b0;
                        n_enable  = 1'b0;
                        n_cool    = 1'b0;
                        n_elapsed = 16'd0;
                    end
                end
            end else if (i_in_data.func == mzdp_pkg::FUNC_REPORT) begin
                bank_ctrl.report = 1'b1;
            end else begin
                // tick: age sensors, advance counters
                bank_ctrl.tick = 1'b1;
                n_period = period_inc;
                n_run    = run_inc;
                if (period_inc >= r_eval_period) begin
                    // evaluation period elapsed
                    bank_ctrl.eval = 1'b1;
                    n_period = 8'd0;
                    if (bank_stat.live_any && !r_motor) begin
                        n_motor  = 1'b1;
                        n_status = 1'b1;
                    end
                    if (!bank_stat.live_any && r_motor) begin
                        n_motor   = 1'b0;
                        n_status  = 1'b0;
                        n_cool    = 1'b1;
                        n_elapsed = 16'd0;
                    end
                    n_enable = bank_stat.live_one;
                end
                // run limit cut, run indicator left as is
                if (n_motor && run_inc >= r_run_limit) begin
                    n_motor   = 1'b0;
                    n_cool    = 1'b1;
                    n_elapsed = 16'd0;
                end
                if (run_inc >= r_run_wrap) begin
                    n_run = 14'd0;
                end
            end
        end
    end

    mzdp_sensor_bank #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (bank_ctrl),
        .i_reload     (r_timeout_reload),
        .o_stat       (bank_stat),
        .o_flags_next (flags_next)
    );

    // result as it stands after this request; flags beyond the field read zero
    always_comb begin
        n_out = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < NUM_SENSORS) begin
                n_out.sensor_flags[i] = flags_next[i];
            end
        end
        n_out.motor_on        = n_motor;
        n_out.run_indicator   = n_status;
        n_out.single_enable   = n_enable;
        n_out.cooldown_active = n_cool;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= 8'd0;
            r_run       <= 14'd0;
            r_motor     <= 1'b0;
            r_status    <= 1'b0;
            r_enable    <= 1'b0;
            r_cool      <= 1'b0;
            r_elapsed   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_period  <= n_period;
            r_run     <= n_run;
            r_motor   <= n_motor;
            r_status  <= n_status;
            r_enable  <= n_enable;
            r_cool    <= n_cool;
            r_elapsed <= n_elapsed;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_reload <= mzdp_pkg::RST_TIMEOUT_RELOAD;
            r_eval_period    <= mzdp_pkg::RST_EVAL_PERIOD;
            r_run_limit      <= mzdp_pkg::RST_RUN_LIMIT;
            r_run_wrap       <= mzdp_pkg::RST_RUN_WRAP;
            r_cooldown_ticks <= mzdp_pkg::RST_COOLDOWN_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mzdp_pkg::CFG_TIMEOUT_RELOAD: r_timeout_reload <= i_cfg_data[7:0];
                mzdp_pkg::CFG_EVAL_PERIOD:    r_eval_period    <= i_cfg_data[7:0];
                mzdp_pkg::CFG_RUN_LIMIT:      r_run_limit      <= i_cfg_data[13:0];
                mzdp_pkg::CFG_RUN_WRAP:       r_run_wrap       <= i_cfg_data[13:0];
                mzdp_pkg::CFG_COOLDOWN_TICKS: r_cooldown_ticks <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // quiet cycles (nothing accepted, delivered or written) before giving up
    localparam int QUIET_LIMIT = 2000;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    mzdp_pkg::t_request              i_in_data  = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    mzdp_pkg::t_result               o_out_data;
    logic                            i_cfg_we   = 1'b0;
    logic [mzdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [mzdp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    multi_zone_demand_pump_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // expected pump status, one entry per accepted request
    mzdp_pkg::t_result pending_status[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      hold_len       = 0;
    int      hold_left      = 0;
    int      quiet_cycles   = 0;

    // register copies
    logic [7:0]  cfg_reload = mzdp_pkg::RST_TIMEOUT_RELOAD;
    logic [7:0]  cfg_period = mzdp_pkg::RST_EVAL_PERIOD;
    logic [13:0] cfg_limit  = mzdp_pkg::RST_RUN_LIMIT;
    logic [13:0] cfg_wrap   = mzdp_pkg::RST_RUN_WRAP;
    logic [15:0] cfg_cool   = mzdp_pkg::RST_COOLDOWN_TICKS;

    // controller state as the predictor sees it
    logic [7:0]  zone_timer [8] = '{default: 8'd0};
    logic [7:0]  flag_bits    = '0;
    logic [7:0]  period_cnt   = '0;
    logic [13:0] run_cnt      = '0;
    logic        motor        = 1'b0;
    logic        run_status   = 1'b0;
    logic        single_zone  = 1'b0;
    logic        cooling      = 1'b0;
    logic [15:0] cool_elapsed = '0;
    logic        report_dropped = 1'b0;

    function automatic void clear_pump_state();
        for (int i = 0; i < 8; i++) zone_timer[i] = 8'd0;
        flag_bits    = '0;
        period_cnt   = '0;
        run_cnt      = '0;
        motor        = 1'b0;
        run_status   = 1'b0;
        single_zone  = 1'b0;
        cooling      = 1'b0;
        cool_elapsed = '0;
    endfunction

    // status after one request, updating the state copy
    function automatic mzdp_pkg::t_result next_pump_status(input mzdp_pkg::t_request req);
        int                live;
        mzdp_pkg::t_result res;
        report_dropped = 1'b0;
        if (cooling) begin
            if (req.func == mzdp_pkg::FUNC_TICK) begin
                if (cool_elapsed != 16'hFFFF) cool_elapsed++;
                if (cool_elapsed >= cfg_cool) clear_pump_state();
            end else begin
                report_dropped = 1'b1;
            end
        end else if (req.func == mzdp_pkg::FUNC_REPORT) begin
            flag_bits[req.sensor_index] = req.report_on;
            if (req.report_on) zone_timer[req.sensor_index] = cfg_reload;
        end else begin
            for (int i = 0; i < 8; i++)
                if (zone_timer[i] != 0) zone_timer[i]--;
            period_cnt++;
            run_cnt++;
            if (period_cnt >= cfg_period) begin
                // evaluation: dead zones lose their flag
                live = 0;
                for (int i = 0; i < 8; i++) begin
                    if (zone_timer[i] != 0) live++;
                    else flag_bits[i] = 1'b0;
                end
                if (live >= 1 && !motor) begin
                    motor      = 1'b1;
                    run_status = 1'b1;
                end
                if (live == 0 && motor) begin
                    motor        = 1'b0;
                    run_status   = 1'b0;
                    cooling      = 1'b1;
                    cool_elapsed = '0;
                end
                single_zone = (live == 1);
                period_cnt  = '0;
            end
            // run limit cut keeps the run status as it was
            if (motor && run_cnt >= cfg_limit) begin
                motor        = 1'b0;
                cooling      = 1'b1;
                cool_elapsed = '0;
            end
            if (run_cnt >= cfg_wrap) run_cnt = '0;
        end
        res.sensor_flags    = flag_bits;
        res.motor_on        = motor;
        res.run_indicator   = run_status;
        res.single_enable   = single_zone;
        res.cooldown_active = cooling;
        return res;
    endfunction

    // result side: random stalls, plus a long hold when asked for
    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        mzdp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                $error("result with no request outstanding: %h", o_out_data);
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                if (o_out_data.sensor_flags !== want.sensor_flags) begin
                    $error("sensor_flags: expected %h, actual %h",
                           want.sensor_flags, o_out_data.sensor_flags);
                    mismatch_count++;
                end
                if (o_out_data.motor_on !== want.motor_on) begin
                    $error("motor_on: expected %b, actual %b",
                           want.motor_on, o_out_data.motor_on);
                    mismatch_count++;
                end
                if (o_out_data.run_indicator !== want.run_indicator) begin
                    $error("run_indicator: expected %b, actual %b",
                           want.run_indicator, o_out_data.run_indicator);
                    mismatch_count++;
                end
                if (o_out_data.single_enable !== want.single_enable) begin
                    $error("single_enable: expected %b, actual %b",
                           want.single_enable, o_out_data.single_enable);
                    mismatch_count++;
                end
                if (o_out_data.cooldown_active !== want.cooldown_active) begin
                    $error("cooldown_active: expected %b, actual %b",
                           want.cooldown_active, o_out_data.cooldown_active);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[multi_zone_demand_pump_controller] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid stays high after acceptance; the next call decides whether it drops
    task automatic send_request(input mzdp_pkg::t_request req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_status.push_back(next_pump_status(req));
    endtask

    function automatic mzdp_pkg::t_request make_request(input logic func, input int idx,
                                                        input logic on);
        mzdp_pkg::t_request req;
        req.func         = func;
        req.sensor_index = 3'(idx);
        req.report_on    = on;
        return req;
    endfunction

    // mostly ticks and on reports, some raw noise
    function automatic mzdp_pkg::t_request random_request(input int tick_pct);
        mzdp_pkg::t_request req;
        req.sensor_index = 3'($urandom_range(7));
        req.report_on    = 1'($urandom_range(1));
        if ($urandom_range(99) < 10) begin
            req.func = 1'($urandom_range(1));
        end else if ($urandom_range(99) < tick_pct) begin
            req.func = mzdp_pkg::FUNC_TICK;
        end else begin
            req.func      = mzdp_pkg::FUNC_REPORT;
            req.report_on = ($urandom_range(99) < 80);
        end
        return req;
    endfunction

    // drop valid, let every result drain, allow for the output register
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mzdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mzdp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            mzdp_pkg::CFG_TIMEOUT_RELOAD: cfg_reload = data[7:0];
            mzdp_pkg::CFG_EVAL_PERIOD:    cfg_period = data[7:0];
            mzdp_pkg::CFG_RUN_LIMIT:      cfg_limit  = data[13:0];
            mzdp_pkg::CFG_RUN_WRAP:       cfg_wrap   = data[13:0];
            mzdp_pkg::CFG_COOLDOWN_TICKS: cfg_cool   = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int reload, input int period, input int limit,
                                  input int wrap, input int cool);
        settle_idle();
        write_reg(mzdp_pkg::CFG_TIMEOUT_RELOAD, 16'(reload));
        write_reg(mzdp_pkg::CFG_EVAL_PERIOD, 16'(period));
        write_reg(mzdp_pkg::CFG_RUN_LIMIT, 16'(limit));
        write_reg(mzdp_pkg::CFG_RUN_WRAP, 16'(wrap));
        write_reg(mzdp_pkg::CFG_COOLDOWN_TICKS, 16'(cool));
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_level(input int lo, input int hi, input int mid_lo,
                                      input int mid_hi);
        int roll;
        roll = $urandom_range(9);
        if (roll < 2) return lo;
        if (roll < 4) return hi;
        return $urandom_range(mid_hi, mid_lo);
    endfunction

    // reset values: reports on every zone, one off, an off report on a live zone
    task automatic test_default_config();
        for (int i = 0; i < 8; i++)
            send_request(make_request(mzdp_pkg::FUNC_REPORT, i, i != 3));
        send_request(make_request(mzdp_pkg::FUNC_TICK, 0, 1'b0));
        send_request(make_request(mzdp_pkg::FUNC_TICK, 7, 1'b1));
        send_request(make_request(mzdp_pkg::FUNC_REPORT, 5, 1'b0));
        send_request(make_request(mzdp_pkg::FUNC_TICK, 3, 1'b0));
    endtask

    // motor cut at the run limit, ticks through cooldown, restart after it
    task automatic test_run_limit_cut();
        apply_settings(255, 1, 3, 16383, 1);
        send_request(make_request(mzdp_pkg::FUNC_REPORT, 2, 1'b1));
        send_request(make_request(mzdp_pkg::FUNC_TICK, 0, 1'b0));
        send_request(make_request(mzdp_pkg::FUNC_REPORT, 4, 1'b1));
        send_request(make_request(mzdp_pkg::FUNC_TICK, 0, 1'b0));
        send_request(make_request(mzdp_pkg::FUNC_REPORT, 1, 1'b1));
        repeat (4) send_request(make_request(mzdp_pkg::FUNC_TICK, 6, 1'b1));
    endtask

    // last live zone times out while the motor runs
    task automatic test_last_zone_drop();
        apply_settings(2, 1, 16383, 16383, 1);
        send_request(make_request(mzdp_pkg::FUNC_REPORT, 0, 1'b1));
        repeat (3) send_request(make_request(mzdp_pkg::FUNC_TICK, 0, 1'b0));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int useful;
        int tick_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 6; k++) begin
            if (k == 0)
                apply_settings(1, 1, 1, 1, 1);
            else if (k == 1)
                apply_settings(255, 255, 16383, 16383, 65535);
            else
                apply_settings(pick_level(1, 255, 2, 20), pick_level(1, 255, 1, 8),
                               pick_level(1, 16383, 4, 150),
                               pick_level(1, 16383, 8, 200), $urandom_range(24, 1));
            tick_pct = $urandom_range(75, 40);
            useful   = 0;
            // reports swallowed by cooldown do not count
            while (useful < 100) begin
                send_request(random_request(tick_pct));
                if (!report_dropped) useful++;
            end
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(20, 3, 60, 90, 5);
        hold_len = 48;
        repeat (60) send_request(random_request(55));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_run_limit_cut();
        test_last_zone_drop();
        test_random_traffic(9, 56);
        test_random_traffic(56, 9);
        test_random_traffic(0, 0);
        test_result_backpressure();
        settle_idle();
        if (mismatch_count == 0)
            $display("[multi_zone_demand_pump_controller] OK");
        else
            $display("[multi_zone_demand_pump_controller] ERROR");
        $finish;
    end

endmodule
